// ===== rtl/kbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_pkg
// Types and constants shared by the brute-force nearest neighbor search.
// ----------------------------------------------------------------------------
package kbf_pkg;

	localparam int SQ_W   = 38;
	localparam int IDX_W  = 10;
	localparam int DIST_W = 28;
	localparam int NIDX_W = 25;
	localparam int ROOT_W = 27;
	localparam int RAD_W  = 54;

	localparam logic [SQ_W-1:0]   SQ_ONES   = '1;
	localparam logic [DIST_W-1:0] DIST_ONES = '1;

	localparam logic [1:0] REG_DIMS  = 2'd0;
	localparam logic [1:0] REG_SIZE  = 2'd1;
	localparam logic [1:0] REG_K     = 2'd2;
	localparam logic [1:0] REG_BASE  = 2'd3;

	localparam logic MODE_CORPUS = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [9:0]         point_slot;
		logic [5:0]         dim_slot;
		logic signed [15:0] coord;
	} cmd_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [NIDX_W-1:0] neighbor_index;
		logic              valid_res;
		logic              last;
	} result_t;

	typedef struct packed {
		logic clr;
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== rtl/kbf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_cell
// One rank of the sorted neighbor list: clear, shift up, or insert from candidate or neighbor.
// ----------------------------------------------------------------------------
module kbf_cell import kbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [SQ_W-1:0]  cand_sq,
	input  logic [IDX_W-1:0] cand_idx,
	input  logic             prev_lt,
	input  logic [SQ_W-1:0]  prev_sq,
	input  logic [IDX_W-1:0] prev_idx,
	input  logic [SQ_W-1:0]  next_sq,
	input  logic [IDX_W-1:0] next_idx,
	output logic             lt,
	output logic [SQ_W-1:0]  sq,
	output logic [IDX_W-1:0] idx
);

	logic [SQ_W-1:0]  sq_q;
	logic [IDX_W-1:0] idx_q;

	// strict compare keeps the earlier point ahead on ties
	assign lt  = cand_sq < sq_q;
	assign sq  = sq_q;
	assign idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q  <= SQ_ONES;
			idx_q <= '0;
		end else if (ctl.clr) begin
			sq_q  <= SQ_ONES;
			idx_q <= '0;
		end else if (ctl.shift) begin
			sq_q  <= next_sq;
			idx_q <= next_idx;
		end else if (ctl.ins) begin
			if (prev_lt) begin
				sq_q  <= prev_sq;
				idx_q <= prev_idx;
			end else if (lt) begin
				sq_q  <= cand_sq;
				idx_q <= cand_idx;
			end
		end
	end

endmodule

// ===== rtl/kbf_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbf_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module kbf_sqrt import kbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 3;

	logic [RAD_W-1:0]  op_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [REM_W-1:0]  trial;
	logic [REM_W-1:0]  sub;
	logic              ge;

	assign trial = {rem_q[REM_W-3:0], op_q[RAD_W-1 -: 2]};
	assign sub   = REM_W'({root_q, 2'b01});
	assign ge    = trial >= sub;
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 5'(ROOT_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			op_q   <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			op_q   <= {op_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? trial - sub : trial;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule

// ===== rtl/brute_force_knn_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brute_force_knn_search
// Exact k nearest neighbors by squared Euclidean distance over a point store.
// ----------------------------------------------------------------------------
// Usage: an item on cmd is taken when start is high and busy is low. A corpus
// item (mode 0) writes one coordinate into the point store and returns at
// once. A query item (mode 1) stores one query coordinate; the one at position
// dims_in_use-1 starts a search and busy stays high until all results are out.
// The search walks the store one coordinate per cycle through a three-stage
// read / difference-and-square / accumulate pipe; each finished point is
// offered to a row of MAX_K cells that keep the list sorted. Then each of
// the first k ranks goes in turn through a bit-serial square root.
// Results show on result for one cycle with result_strobe high; the receiver
// cannot stall. cfg_we writes register cfg_index; the user must write it only
// while idle, as the block itself does not enforce it. Reset clears the
// registers to their defaults and the neighbor list; the point and query
// stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module brute_force_knn_search import kbf_pkg::*; #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_DIMS   = 64,
	parameter int MAX_K      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        result_strobe,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);

	localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DCW = $clog2(MAX_DIMS + 1);
	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int KCW = $clog2(MAX_K + 1);
	localparam int AW  = $clog2(MAX_POINTS * MAX_DIMS);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_FLUSH = 5'b00100,
		S_RGO   = 5'b01000,
		S_RWAIT = 5'b10000
	} state_t;

	state_t state_q;

	logic [6:0]  dims_q;
	logic [10:0] size_q;
	logic [4:0]  k_q;
	logic [23:0] base_idx_q;

	logic [DCW-1:0] d_c;
	logic [PCW-1:0] m_c;
	logic [KCW-1:0] k_c;

	always_comb begin
		if (dims_q == '0) d_c = DCW'(1);
		else if (32'(dims_q) > 32'(MAX_DIMS)) d_c = DCW'(MAX_DIMS);
		else d_c = DCW'(dims_q);
		if (size_q == '0) m_c = PCW'(1);
		else if (32'(size_q) > 32'(MAX_POINTS)) m_c = PCW'(MAX_POINTS);
		else m_c = PCW'(size_q);
		if (k_q == '0) k_c = KCW'(1);
		else if (32'(k_q) > 32'(MAX_K)) k_c = KCW'(MAX_K);
		else k_c = KCW'(k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q     <= 7'd1;
			size_q     <= 11'd1;
			k_q        <= 5'd1;
			base_idx_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMS: dims_q     <= cfg_wdata[6:0];
				REG_SIZE: size_q     <= cfg_wdata[10:0];
				REG_K:    k_q        <= cfg_wdata[4:0];
				REG_BASE: base_idx_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// item intake
	logic accept;
	logic slot_ok;
	logic dim_ok;
	logic wr_corpus;
	logic wr_query;
	logic trigger;

	assign busy      = state_q != S_IDLE;
	assign accept    = start && !busy;
	assign dim_ok    = 32'(cmd.dim_slot) < 32'(MAX_DIMS);
	assign slot_ok   = (32'(cmd.point_slot) < 32'(MAX_POINTS)) && dim_ok;
	assign wr_corpus = accept && cmd.mode == MODE_CORPUS && slot_ok;
	assign wr_query  = accept && cmd.mode == MODE_QUERY && dim_ok;
	assign trigger   = wr_query && (32'(cmd.dim_slot) + 32'd1 == 32'(d_c));

	// scan address generation
	logic [DCW-1:0] dm_q;
	logic [PCW-1:0] pt_q;
	logic [AW-1:0]  row_q;
	logic [AW-1:0]  rd_addr;
	logic           last_dm;
	logic           last_pt;

	assign rd_addr = row_q + AW'(dm_q);
	assign last_dm = dm_q == d_c - DCW'(1);
	assign last_pt = pt_q == m_c - PCW'(1);

	// stores
	logic signed [15:0] corpus_mem [MAX_POINTS*MAX_DIMS];
	logic signed [15:0] query_mem  [MAX_DIMS];
	logic signed [15:0] corpus_s1;
	logic signed [15:0] query_s1;

	always_ff @(posedge clk) begin
		if (wr_corpus)
			corpus_mem[AW'(32'(cmd.point_slot) * MAX_DIMS + 32'(cmd.dim_slot))] <= cmd.coord;
		corpus_s1 <= corpus_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_query)
			query_mem[DW'(cmd.dim_slot)] <= cmd.coord;
		query_s1 <= query_mem[dm_q[DW-1:0]];
	end

	// difference, square, accumulate
	logic             v_s1, first_s1, last_s1;
	logic [PCW-1:0]   pt_s1;
	logic             v_s2, first_s2, last_s2;
	logic [PCW-1:0]   pt_s2;
	logic [33:0]      sqr_s2;
	logic [SQ_W-1:0]  acc_q;
	logic [SQ_W-1:0]  acc_next;
	logic             cand_v_s3;
	logic [SQ_W-1:0]  cand_sq_s3;
	logic [IDX_W-1:0] cand_idx_s3;
	logic signed [16:0] diff_s1;
	logic signed [33:0] prod_s1;

	assign diff_s1  = 17'(query_s1) - 17'(corpus_s1);
	assign prod_s1  = diff_s1 * diff_s1;
	assign acc_next = (first_s2 ? '0 : acc_q) + SQ_W'(sqr_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			cand_v_s3 <= 1'b0;
		end else begin
			v_s1      <= state_q == S_SCAN;
			v_s2      <= v_s1;
			cand_v_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= dm_q == '0;
		last_s1  <= last_dm;
		pt_s1    <= pt_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		pt_s2    <= pt_s1;
		sqr_s2   <= prod_s1[33:0];
		if (v_s2)
			acc_q <= acc_next;
		cand_sq_s3  <= acc_next;
		cand_idx_s3 <= IDX_W'(pt_s2);
	end

	// sorted list of k best
	cell_ctl_t        ctl;
	logic             lt_w  [MAX_K];
	logic [SQ_W-1:0]  sq_w  [MAX_K];
	logic [IDX_W-1:0] idx_w [MAX_K];
	logic             root_done;
	logic [ROOT_W-1:0] root;

	assign ctl.clr   = trigger;
	assign ctl.ins   = cand_v_s3;
	assign ctl.shift = (state_q == S_RWAIT) && root_done;

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		logic             p_lt;
		logic [SQ_W-1:0]  p_sq, n_sq;
		logic [IDX_W-1:0] p_idx, n_idx;
		if (i == 0) begin : g_head
			assign p_lt  = 1'b0;
			assign p_sq  = SQ_ONES;
			assign p_idx = '0;
		end else begin : g_mid
			assign p_lt  = lt_w[i-1];
			assign p_sq  = sq_w[i-1];
			assign p_idx = idx_w[i-1];
		end
		if (i == MAX_K - 1) begin : g_tail
			assign n_sq  = SQ_ONES;
			assign n_idx = '0;
		end else begin : g_body
			assign n_sq  = sq_w[i+1];
			assign n_idx = idx_w[i+1];
		end
		kbf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.cand_sq  (cand_sq_s3),
			.cand_idx (cand_idx_s3),
			.prev_lt  (p_lt),
			.prev_sq  (p_sq),
			.prev_idx (p_idx),
			.next_sq  (n_sq),
			.next_idx (n_idx),
			.lt       (lt_w[i]),
			.sq       (sq_w[i]),
			.idx      (idx_w[i])
		);
	end

	kbf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (state_q == S_RGO),
		.radicand ({sq_w[0][RAD_W-17:0], 16'h0000}),
		.done     (root_done),
		.root     (root)
	);

	// control
	logic [2:0]     flush_q;
	logic [KCW-1:0] rk_q;
	logic           last_rk;
	logic           head_valid;

	assign last_rk    = rk_q == k_c - KCW'(1);
	assign head_valid = sq_w[0] != SQ_ONES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			dm_q          <= '0;
			pt_q          <= '0;
			row_q         <= '0;
			flush_q       <= '0;
			rk_q          <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					dm_q  <= '0;
					pt_q  <= '0;
					row_q <= '0;
					rk_q  <= '0;
					if (trigger)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (last_dm) begin
						dm_q  <= '0;
						pt_q  <= pt_q + PCW'(1);
						row_q <= row_q + AW'(MAX_DIMS);
						if (last_pt) begin
							flush_q <= '0;
							state_q <= S_FLUSH;
						end
					end else begin
						dm_q <= dm_q + DCW'(1);
					end
				end
				S_FLUSH: begin
					flush_q <= flush_q + 3'd1;
					if (flush_q == 3'd4)
						state_q <= S_RGO;
				end
				S_RGO: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (root_done) begin
						result_strobe <= 1'b1;
						rk_q          <= rk_q + KCW'(1);
						state_q       <= last_rk ? S_IDLE : S_RGO;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RWAIT && root_done) begin
			result.valid_res <= head_valid;
			result.last      <= last_rk;
			if (head_valid) begin
				result.distance       <= DIST_W'(root);
				result.neighbor_index <= NIDX_W'(idx_w[0]) + NIDX_W'(base_idx_q);
			end else begin
				result.distance       <= DIST_ONES;
				result.neighbor_index <= '0;
			end
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_cand_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cand_v_s3 |-> (state_q == S_SCAN || state_q == S_FLUSH))
		else $error("candidate outside search");
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(state_q == S_RWAIT))
		else $error("result without root");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |-> state_q == S_IDLE)
		else $error("last result while still busy");

endmodule
